// File: design/rdtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdtp_pkg
// Field widths and codes shared by the row displacement packer files.
// ----------------------------------------------------------------------------
package rdtp_pkg;

  localparam int REQ_W    = 1;
  localparam int STATE_W  = 10;
  localparam int ACTION_W = 16;
  localparam int RADDR_W  = 12;
  localparam int BASE_W   = 12;
  localparam int USED_W   = 13;
  localparam int CHECK_W  = 11;
  localparam int NEXT_W   = 16;
  localparam int ROWLEN_W = 9;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD = 1'b0;
  localparam logic [REQ_W-1:0] REQ_READ = 1'b1;

  // Register index of row_length
  localparam logic REG_ROW_LENGTH = 1'b0;

  typedef logic [CHECK_W-1:0]  check_t;
  typedef logic [ACTION_W-1:0] action_t;

  // One packed table entry: owning row plus one, and the stored action.
  typedef struct packed {
    check_t  check;
    action_t next;
  } entry_t;

endpackage

// File: design/rdtp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdtp_if
// Request and result channels of the row displacement packer.
// ----------------------------------------------------------------------------
interface rdtp_in_if;
  import rdtp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [STATE_W-1:0]         state_id;
  logic signed [ACTION_W-1:0] action_value;
  logic                       last;
  logic [RADDR_W-1:0]         read_address;

  modport source (output valid, req_type, state_id, action_value, last, read_address,
                  input ready);
  modport sink (input valid, req_type, state_id, action_value, last, read_address,
                output ready);
endinterface

interface rdtp_out_if;
  import rdtp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [BASE_W-1:0]        base_index;
  logic                     overflow;
  logic [USED_W-1:0]        used_length;
  logic [CHECK_W-1:0]       check_value;
  logic signed [NEXT_W-1:0] next_value;

  modport source (output valid, base_index, overflow, used_length, check_value, next_value,
                  input ready);
  modport sink (input valid, base_index, overflow, used_length, check_value, next_value,
                output ready);
endinterface

// File: design/rdtp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdtp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rdtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/row_displacement_table_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_displacement_table_packer
// Packs sparse rows into shared check/next arrays by first-fit displacement.
// ----------------------------------------------------------------------------
// After reset the block clears every table entry and takes no transaction
// meanwhile. Load elements are then taken while the block is idle, and a read
// registers the table entry in the RAM and then its result in the output
// register once the output slot is free. At row end the search tests one
// column against one table entry at a time, through the single read port of
// the table RAM, in a probe state and an evaluate state; the write-back then
// reads each column from the row buffer and writes it if it is nonzero. An
// empty table, or an empty row, skips the search.
// Input is held off while the search and write-back run.
// ----------------------------------------------------------------------------
module row_displacement_table_packer #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 1024,
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rdtp_in_if.sink                         in_ch,
  rdtp_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rdtp_pkg::APB_AW-1:0]     cfg_paddr,
  input  logic [rdtp_pkg::APB_DW-1:0]     cfg_pwdata,
  output logic [rdtp_pkg::APB_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import rdtp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int LW = CW + 1;
  localparam int UW = AW + 1;
  localparam int SW = ((UW > LW) ? UW : LW) + 1;
  localparam int TW = CHECK_W + ACTION_W;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_PROBE   = 3'd3;
  localparam logic [2:0] ST_EVAL    = 3'd4;
  localparam logic [2:0] ST_PLACE   = 3'd5;
  localparam logic [2:0] ST_WR_RD   = 3'd6;
  localparam logic [2:0] ST_WR_WR   = 3'd7;
  // Result assembly shares ST_PLACE's decision; done is flagged separately.

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [LW-1:0]       cnt_r, cnt_nxt;
  logic [UW-1:0]       used_r, used_nxt;
  logic [UW-1:0]       base_r, base_nxt;
  logic [LW-1:0]       j_r, j_nxt;
  logic [LW-1:0]       jlim_r, jlim_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  check_t              tag_r, tag_nxt;
  logic                ovf_r, ovf_nxt;
  logic                done_r, done_nxt;
  logic                oob_r, oob_nxt;
  logic [ROWLEN_W-1:0] row_length_r;

  logic                out_valid_r, out_valid_nxt;
  logic [BASE_W-1:0]   out_base_r, out_base_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic [USED_W-1:0]   out_used_r, out_used_nxt;
  check_t              out_chk_r, out_chk_nxt;
  action_t             out_next_r, out_next_nxt;

  logic [LW-1:0]       eff_len;
  logic [LW-1:0]       cnt_after;
  logic [SW-1:0]       probe_addr;
  logic [SW-1:0]       row_end;
  logic                slot_free;
  logic                in_acc;

  logic                tbl_we, tbl_re;
  logic [AW-1:0]       tbl_waddr, tbl_raddr;
  entry_t              tbl_wdata, tbl_rdata;
  logic                rb_we, rb_re;
  logic [CW-1:0]       rb_waddr, rb_raddr;
  action_t             rb_rdata;

  rdtp_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  rdtp_ram #(.WIDTH(ACTION_W), .DEPTH(MAX_COLUMNS)) u_row_ram (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (in_ch.action_value),
    .re    (rb_re),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ROW_LENGTH) ? APB_DW'(row_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROWLEN_W'(256);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_ROW_LENGTH) begin
      row_length_r <= cfg_pwdata[ROWLEN_W-1:0];
    end
  end

  always_comb begin
    if (row_length_r == '0) begin
      eff_len = LW'(1);
    end else if (32'(row_length_r) > MAX_COLUMNS) begin
      eff_len = LW'(MAX_COLUMNS);
    end else begin
      eff_len = LW'(row_length_r);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign probe_addr  = SW'(base_r) + SW'(j_r);
  assign row_end     = SW'(base_r) + SW'(len_r);
  assign cnt_after   = (cnt_r < eff_len) ? cnt_r + LW'(1) : cnt_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    base_nxt      = base_r;
    j_nxt         = j_r;
    jlim_nxt      = jlim_r;
    len_nxt       = len_r;
    tag_nxt       = tag_r;
    ovf_nxt       = ovf_r;
    done_nxt      = done_r;
    oob_nxt       = oob_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_base_nxt  = out_base_r;
    out_ovf_nxt   = out_ovf_r;
    out_used_nxt  = out_used_r;
    out_chk_nxt   = out_chk_r;
    out_next_nxt  = out_next_r;
    tbl_we        = 1'b0;
    tbl_waddr     = probe_addr[AW-1:0];
    tbl_wdata     = '{check: tag_r, next: rb_rdata};
    tbl_re        = 1'b0;
    tbl_raddr     = probe_addr[AW-1:0];
    rb_we         = 1'b0;
    rb_waddr      = cnt_r[CW-1:0];
    rb_re         = 1'b0;
    rb_raddr      = j_r[CW-1:0];

    case (state_r)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        tbl_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && in_ch.req_type == REQ_READ) begin
          tbl_re    = 1'b1;
          tbl_raddr = AW'(in_ch.read_address);
          oob_nxt   = 32'(in_ch.read_address) >= TABLE_DEPTH;
          state_nxt = ST_READ;
        end else if (in_acc) begin
          rb_we   = cnt_r < eff_len;
          cnt_nxt = cnt_after;
          if (in_ch.last) begin
            len_nxt  = eff_len;
            jlim_nxt = (cnt_after < eff_len) ? cnt_after : eff_len;
            if (32'(in_ch.state_id) > MAX_ROWS - 1) begin
              tag_nxt = CHECK_W'(MAX_ROWS);
            end else begin
              tag_nxt = CHECK_W'(32'(in_ch.state_id) + 32'd1);
            end
            base_nxt = '0;
            j_nxt    = '0;
            // An empty row, or an empty table, takes base zero at once.
            if (used_r == '0 || cnt_after == '0) begin
              state_nxt = ST_PLACE;
            end else begin
              state_nxt = ST_PROBE;
            end
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_base_nxt  = '0;
          out_ovf_nxt   = 1'b0;
          out_used_nxt  = USED_W'(used_r);
          out_chk_nxt   = oob_r ? '0 : tbl_rdata.check;
          out_next_nxt  = oob_r ? '0 : tbl_rdata.next;
          state_nxt     = ST_IDLE;
        end
      end
      ST_PROBE: begin
        tbl_re    = 1'b1;
        rb_re     = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (rb_rdata != '0 && probe_addr < SW'(TABLE_DEPTH) && tbl_rdata.check != '0) begin
          j_nxt = '0;
          if (base_r + UW'(1) == used_r) begin
            base_nxt  = used_r;
            state_nxt = ST_PLACE;
          end else begin
            base_nxt  = base_r + UW'(1);
            state_nxt = ST_PROBE;
          end
        end else if (j_r + LW'(1) == jlim_r) begin
          j_nxt     = '0;
          state_nxt = ST_PLACE;
        end else begin
          j_nxt     = j_r + LW'(1);
          state_nxt = ST_PROBE;
        end
      end
      ST_PLACE: begin
        if (!done_r) begin
          ovf_nxt = row_end > SW'(TABLE_DEPTH);
          if (row_end > SW'(TABLE_DEPTH) || jlim_r == '0) begin
            if (row_end <= SW'(TABLE_DEPTH) && row_end > SW'(used_r)) begin
              used_nxt = UW'(row_end);
            end
            done_nxt = 1'b1;
          end else begin
            j_nxt     = '0;
            state_nxt = ST_WR_RD;
          end
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_base_nxt  = ovf_r ? '0 : BASE_W'(base_r);
          out_ovf_nxt   = ovf_r;
          out_used_nxt  = USED_W'(used_r);
          out_chk_nxt   = '0;
          out_next_nxt  = '0;
          cnt_nxt       = '0;
          done_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_WR_RD: begin
        rb_re     = 1'b1;
        state_nxt = ST_WR_WR;
      end
      ST_WR_WR: begin
        tbl_we = rb_rdata != '0;
        if (j_r + LW'(1) == jlim_r) begin
          if (row_end > SW'(used_r)) begin
            used_nxt = UW'(row_end);
          end
          done_nxt  = 1'b1;
          state_nxt = ST_PLACE;
        end else begin
          j_nxt     = j_r + LW'(1);
          state_nxt = ST_WR_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      used_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    j_r        <= j_nxt;
    jlim_r     <= jlim_nxt;
    len_r      <= len_nxt;
    tag_r      <= tag_nxt;
    ovf_r      <= ovf_nxt;
    oob_r      <= oob_nxt;
    out_base_r <= out_base_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_used_r <= out_used_nxt;
    out_chk_r  <= out_chk_nxt;
    out_next_r <= out_next_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.base_index  = out_base_r;
  assign out_ch.overflow    = out_ovf_r;
  assign out_ch.used_length = out_used_r;
  assign out_ch.check_value = out_chk_r;
  assign out_ch.next_value  = out_next_r;

endmodule

// File: design/rdtp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdtp_checker
// Port-level checks on the result channel of the row displacement packer.
// ----------------------------------------------------------------------------
module rdtp_checker #(
  parameter int TABLE_DEPTH = 4096
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rdtp_pkg::BASE_W-1:0]  base_index,
  input logic                         overflow,
  input logic [rdtp_pkg::USED_W-1:0]  used_length,
  input logic [rdtp_pkg::CHECK_W-1:0] check_value,
  input logic [rdtp_pkg::NEXT_W-1:0]  next_value
);
  import rdtp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_ovf_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> base_index == '0 && check_value == '0 && next_value == '0)
    else $error("overflow result carries stray fields");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && check_value != '0 |-> !overflow && base_index == '0)
    else $error("read result carries placement fields");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(used_length) <= TABLE_DEPTH)
    else $error("used length beyond table depth");

endmodule

bind row_displacement_table_packer rdtp_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_rdtp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .base_index  (out_ch.base_index),
  .overflow    (out_ch.overflow),
  .used_length (out_ch.used_length),
  .check_value (out_ch.check_value),
  .next_value  (out_ch.next_value)
);
